// File: rtl/lmd_pkg.sv
// Shared types and constants for the label mode downsampler.
// No dependencies; used by every module of the block.
`default_nettype none

package lmd_pkg;

    localparam int MAX_WIDTH_DEF  = 512;
    localparam int MAX_FACTOR_DEF = 16;
    localparam int NUM_LABELS_DEF = 256;

    localparam logic [7:0]  IGNORE_LABEL = 8'd255;
    localparam logic [8:0]  COUNT_MAX    = 9'd511;
    localparam logic [12:0] HEIGHT_MAX   = 13'd4096;

    localparam logic [4:0]  FACTOR_RST = 5'd2;
    localparam logic [9:0]  WIDTH_RST  = 10'd512;
    localparam logic [12:0] HEIGHT_RST = 13'd512;

    // Per-column generation counter used to retire histogram bins without clearing them.
    localparam int EPOCH_W = 16;
    localparam int Q_DEPTH = 4;
    localparam int OC_W    = 12;

    typedef enum logic [1:0] {
        CFG_FACTOR = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2
    } lmd_cfg_idx_t;

    typedef enum logic {
        FS_RECALC = 1'b0,
        FS_RUN    = 1'b1
    } lmd_front_state_t;

    typedef enum logic {
        BS_CLEAR = 1'b0,
        BS_RUN   = 1'b1
    } lmd_back_state_t;

    // Clamped configuration as seen by the datapath.
    typedef struct packed {
        logic [6:0]  f;
        logic [12:0] w;
        logic [12:0] h;
        logic [12:0] half;
    } lmd_cfg_t;

    // One classified pixel travelling from front to back.
    typedef struct packed {
        logic [7:0]      lab;
        logic [OC_W-1:0] oc;
        logic [11:0]     orow;
        logic            emit;
        logic            last;
    } lmd_item_t;

endpackage

`default_nettype wire

// File: rtl/lmd_front.sv
// Front end: tracks the raster position and classifies each accepted pixel.
// Depends on lmd_pkg.
`default_nettype none

module lmd_front #(
    parameter int MAX_WIDTH  = lmd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_FACTOR = lmd_pkg::MAX_FACTOR_DEF,
    parameter int NUM_LABELS = lmd_pkg::NUM_LABELS_DEF
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  lmd_pkg::lmd_cfg_t  cfg,
    input  wire                cfg_write,
    input  wire                back_run,
    input  wire                s_valid,
    output logic               s_ready,
    input  wire [7:0]          s_label,
    output logic               push_valid,
    input  wire                push_ready,
    output lmd_pkg::lmd_item_t push_item
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int FW = $clog2(MAX_FACTOR + 1);

    lmd_pkg::lmd_front_state_t state_reg, state_next;

    logic [CW-1:0] col_reg, col_next;
    logic [11:0]   row_reg, row_next;
    logic [FW-1:0] cin_reg, cin_next;
    logic [FW-1:0] rin_reg, rin_next;
    logic [CW-1:0] oc_reg, oc_next;
    logic [11:0]   orow_reg, orow_next;
    logic          colfit_reg, colfit_next;
    logic          rowfit_reg, rowfit_next;
    logic [CW-1:0] rc_reg, rc_next;
    logic [11:0]   rr_reg, rr_next;

    logic [12:0] col_x, row_x, f13;
    logic        col_wrap, row_wrap, cend, rend, counted, accept;
    logic        rc_more, rr_more;

    always_comb begin
        col_x    = 13'(col_reg);
        row_x    = 13'(row_reg);
        f13      = 13'(cfg.f);
        col_wrap = (col_x + 13'd1) >= cfg.w;
        row_wrap = (row_x + 13'd1) >= cfg.h;
        cend     = (7'(cin_reg) + 7'd1) == cfg.f;
        rend     = (7'(rin_reg) + 7'd1) == cfg.f;
        counted  = colfit_reg && rowfit_reg;
        rc_more  = 13'(rc_reg) >= f13;
        rr_more  = 13'(rr_reg) >= f13;

        // A configuration transfer takes priority over a pixel in the same cycle.
        s_ready    = (state_reg == lmd_pkg::FS_RUN) && back_run && push_ready && !cfg_write;
        accept     = s_valid && s_ready;
        push_valid = accept && counted;

        push_item.lab  = (9'(s_label) >= 9'(NUM_LABELS)) ? 8'(NUM_LABELS - 1) : s_label;
        push_item.oc   = lmd_pkg::OC_W'(oc_reg);
        push_item.orow = orow_reg;
        push_item.emit = cend && rend;
        push_item.last = ((col_x + 13'd1 + f13) > cfg.w) && ((row_x + 13'd1 + f13) > cfg.h);
    end

    always_comb begin
        state_next  = state_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        cin_next    = cin_reg;
        rin_next    = rin_reg;
        oc_next     = oc_reg;
        orow_next   = orow_reg;
        colfit_next = colfit_reg;
        rowfit_next = rowfit_reg;
        rc_next     = rc_reg;
        rr_next     = rr_reg;

        if (cfg_write) begin
            // Position is kept; region counters are rebuilt by repeated subtraction.
            state_next = lmd_pkg::FS_RECALC;
            rc_next    = col_reg;
            rr_next    = row_reg;
            oc_next    = '0;
            orow_next  = '0;
        end else begin
            case (state_reg)
                lmd_pkg::FS_RECALC: begin
                    if (rc_more) begin
                        rc_next = rc_reg - CW'(cfg.f);
                        oc_next = oc_reg + 1'b1;
                    end
                    if (rr_more) begin
                        rr_next   = rr_reg - 12'(cfg.f);
                        orow_next = orow_reg + 12'd1;
                    end
                    if (!rc_more && !rr_more) begin
                        cin_next    = FW'(rc_reg);
                        rin_next    = FW'(rr_reg);
                        colfit_next = (col_x - 13'(rc_reg) + f13) <= cfg.w;
                        rowfit_next = (row_x - 13'(rr_reg) + f13) <= cfg.h;
                        state_next  = lmd_pkg::FS_RUN;
                    end
                end
                lmd_pkg::FS_RUN: begin
                    if (accept) begin
                        if (col_wrap) begin
                            col_next    = '0;
                            cin_next    = '0;
                            oc_next     = '0;
                            colfit_next = f13 <= cfg.w;
                            if (row_wrap) begin
                                row_next    = '0;
                                rin_next    = '0;
                                orow_next   = '0;
                                rowfit_next = f13 <= cfg.h;
                            end else begin
                                row_next = row_reg + 12'd1;
                                if (rend) begin
                                    rin_next    = '0;
                                    orow_next   = orow_reg + 12'd1;
                                    rowfit_next = (row_x + 13'd1 + f13) <= cfg.h;
                                end else begin
                                    rin_next = rin_reg + 1'b1;
                                end
                            end
                        end else begin
                            col_next = col_reg + 1'b1;
                            if (cend) begin
                                cin_next    = '0;
                                oc_next     = oc_reg + 1'b1;
                                colfit_next = (col_x + 13'd1 + f13) <= cfg.w;
                            end else begin
                                cin_next = cin_reg + 1'b1;
                            end
                        end
                    end
                end
                default: state_next = lmd_pkg::FS_RECALC;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lmd_pkg::FS_RECALC;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg    <= '0;
            row_reg    <= '0;
            cin_reg    <= '0;
            rin_reg    <= '0;
            oc_reg     <= '0;
            orow_reg   <= '0;
            colfit_reg <= 1'b0;
            rowfit_reg <= 1'b0;
            rc_reg     <= '0;
            rr_reg     <= '0;
        end else begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            cin_reg    <= cin_next;
            rin_reg    <= rin_next;
            oc_reg     <= oc_next;
            orow_reg   <= orow_next;
            colfit_reg <= colfit_next;
            rowfit_reg <= rowfit_next;
            rc_reg     <= rc_next;
            rr_reg     <= rr_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/lmd_queue.sv
// Small FIFO that decouples the classifying front end from the histogram back end.
// Depends on lmd_pkg.
`default_nettype none

module lmd_queue (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                in_valid,
    output logic               in_ready,
    input  lmd_pkg::lmd_item_t in_item,
    output logic               out_valid,
    input  wire                out_ready,
    output lmd_pkg::lmd_item_t out_item
);

    localparam int PW = $clog2(lmd_pkg::Q_DEPTH);

    lmd_pkg::lmd_item_t slot_reg [lmd_pkg::Q_DEPTH];
    logic [PW-1:0] wr_reg, wr_next;
    logic [PW-1:0] rd_reg, rd_next;
    logic [PW:0]   cnt_reg, cnt_next;
    logic          push, pop;

    always_comb begin
        in_ready  = cnt_reg != (PW+1)'(lmd_pkg::Q_DEPTH);
        out_valid = cnt_reg != '0;
        out_item  = slot_reg[rd_reg];
        push      = in_valid && in_ready;
        pop       = out_valid && out_ready;
        wr_next   = push ? wr_reg + 1'b1 : wr_reg;
        rd_next   = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next  = cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/lmd_back.sv
// Back end: histogram read-modify-write with forwarding, running mode and result register.
// Depends on lmd_pkg; holds the bin and per-column memories.
`default_nettype none

module lmd_back #(
    parameter int MAX_WIDTH  = lmd_pkg::MAX_WIDTH_DEF,
    parameter int NUM_LABELS = lmd_pkg::NUM_LABELS_DEF
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  lmd_pkg::lmd_cfg_t  cfg,
    output logic               back_run,
    input  wire                q_valid,
    output logic               q_ready,
    input  lmd_pkg::lmd_item_t q_item,
    output logic               m_valid,
    input  wire                m_ready,
    output logic [7:0]         m_out_label,
    output logic [11:0]        m_out_row,
    output logic [8:0]         m_out_col,
    output logic               m_frame_last
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int LW   = (NUM_LABELS > 2) ? $clog2(NUM_LABELS) : 1;
    localparam int AW   = CW + LW;
    localparam int EW   = lmd_pkg::EPOCH_W;
    localparam int BINW = EW + 9;
    localparam int COLW = EW + LW + 9;

    lmd_pkg::lmd_back_state_t state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;

    logic [BINW-1:0] bin_mem [2**AW];
    logic [COLW-1:0] col_mem [2**CW];
    logic [BINW-1:0] bin_rd_reg;
    logic [COLW-1:0] col_rd_reg;

    lmd_pkg::lmd_item_t s1_reg;
    logic               s1_valid_reg, s1_valid_next;

    logic            fwd_flag_reg;
    logic [AW-1:0]   fwd_addr_reg;
    logic [BINW-1:0] fwd_bin_reg;
    logic [CW-1:0]   fwd_oc_reg;
    logic [COLW-1:0] fwd_col_reg;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_label_reg;
    logic [11:0] out_row_reg;
    logic [8:0]  out_col_reg;
    logic        out_last_reg;

    logic [AW-1:0]   q_addr, s1_addr, bin_waddr;
    logic [CW-1:0]   s1_oc, col_waddr;
    logic [BINW-1:0] bin_word, bin_wdata;
    logic [COLW-1:0] col_word, col_wdata;
    logic            bin_we, col_we;
    logic [EW-1:0]   ep;
    logic [LW-1:0]   bl, s1_lab, nbl;
    logic [8:0]      bc, cnt_old, cnt_new, nbc;
    logic            s1_done, s1_adv, pop, take_new;

    always_comb begin
        back_run = state_reg == lmd_pkg::BS_RUN;
        q_addr   = {q_item.oc[CW-1:0], q_item.lab[LW-1:0]};
        s1_oc    = s1_reg.oc[CW-1:0];
        s1_lab   = s1_reg.lab[LW-1:0];
        s1_addr  = {s1_oc, s1_lab};

        s1_done = s1_valid_reg && (!s1_reg.emit || !out_valid_reg || m_ready);
        s1_adv  = !s1_valid_reg || s1_done;
        pop     = back_run && q_valid && s1_adv;
        q_ready = back_run && s1_adv;

        // A write that lands in the same cycle as our read is not seen by the memory.
        col_word = (fwd_flag_reg && fwd_oc_reg == s1_oc) ? fwd_col_reg : col_rd_reg;
        bin_word = (fwd_flag_reg && fwd_addr_reg == s1_addr) ? fwd_bin_reg : bin_rd_reg;
        ep       = col_word[COLW-1 -: EW];
        bl       = col_word[9 +: LW];
        bc       = col_word[8:0];
        cnt_old  = (bin_word[BINW-1 -: EW] == ep) ? bin_word[8:0] : 9'd0;
        cnt_new  = (cnt_old == lmd_pkg::COUNT_MAX) ? cnt_old : cnt_old + 9'd1;

        if (cnt_new > bc || (cnt_new == bc && s1_lab < bl)) begin
            nbc = cnt_new;
            nbl = s1_lab;
        end else begin
            nbc = bc;
            nbl = bl;
        end

        if (state_reg == lmd_pkg::BS_CLEAR) begin
            bin_we    = 1'b1;
            bin_waddr = clr_reg;
            bin_wdata = '0;
            col_we    = 1'b1;
            col_waddr = clr_reg[CW-1:0];
            col_wdata = '0;
        end else begin
            bin_we    = s1_done;
            bin_waddr = s1_addr;
            bin_wdata = {ep, cnt_new};
            col_we    = s1_done;
            col_waddr = s1_oc;
            // Closing a region bumps the column epoch, retiring all its bins at once.
            col_wdata = s1_reg.emit ? {ep + 1'b1, {(LW+9){1'b0}}} : {ep, nbl, nbc};
        end

        take_new      = s1_done && s1_reg.emit;
        s1_valid_next = pop ? 1'b1 : (s1_done ? 1'b0 : s1_valid_reg);
        if (take_new) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end

        state_next = state_reg;
        clr_next   = clr_reg;
        case (state_reg)
            lmd_pkg::BS_CLEAR: begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == {AW{1'b1}}) begin
                    state_next = lmd_pkg::BS_RUN;
                end
            end
            lmd_pkg::BS_RUN: state_next = lmd_pkg::BS_RUN;
            default: state_next = lmd_pkg::BS_CLEAR;
        endcase

        m_valid      = out_valid_reg;
        m_out_label  = out_label_reg;
        m_out_row    = out_row_reg;
        m_out_col    = out_col_reg;
        m_frame_last = out_last_reg;
    end

    always_ff @(posedge aclk) begin
        if (bin_we) begin
            bin_mem[bin_waddr] <= bin_wdata;
        end
        if (pop) begin
            bin_rd_reg <= bin_mem[q_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (col_we) begin
            col_mem[col_waddr] <= col_wdata;
        end
        if (pop) begin
            col_rd_reg <= col_mem[q_item.oc[CW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            s1_reg <= q_item;
        end
        if (s1_done) begin
            fwd_addr_reg <= s1_addr;
            fwd_bin_reg  <= bin_wdata;
            fwd_oc_reg   <= s1_oc;
            fwd_col_reg  <= col_wdata;
        end
        if (take_new) begin
            out_label_reg <= (13'(nbc) > cfg.half) ? 8'(nbl) : lmd_pkg::IGNORE_LABEL;
            out_row_reg   <= s1_reg.orow;
            out_col_reg   <= 9'(s1_oc);
            out_last_reg  <= s1_reg.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lmd_pkg::BS_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_flag_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            clr_reg       <= clr_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (pop) begin
                fwd_flag_reg <= s1_done;
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == lmd_pkg::BS_CLEAR |-> !pop && !s1_valid_reg)
        else $error("histogram item issued during the clearing pass");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s1_done |-> cnt_new != 9'd0)
        else $error("bin count did not advance");

    assert property (@(posedge aclk) disable iff (!aresetn)
        take_new |=> out_valid_reg && fwd_col_reg[COLW-1 -: EW] == $past(ep) + 1'b1)
        else $error("closed region did not retire its column");

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready && s1_valid_reg && s1_reg.emit |-> !s1_done)
        else $error("result overwritten while still pending");

endmodule

`default_nettype wire

// File: rtl/label_mode_downsample.sv
// Top level of the majority-vote label downsampler: configuration registers and wiring.
// Depends on lmd_pkg, lmd_front, lmd_queue and lmd_back.
`default_nettype none

// Majority-vote downsampler for label maps. Labels enter one per cycle in raster
// order while s_ready is high; each region_factor x region_factor region yields
// its most frequent label (smallest label wins ties), or 255 when that label does
// not hold more than half of the region. A pixel is taken every cycle in steady
// state unless m_ready holds back the results; the result of a region-closing pixel
// passes through the queue, the histogram read-modify-write and the result register
// before it is presented on m_valid. After reset the histogram memory is swept
// once, one bin a cycle, before s_ready rises. After each configuration transfer
// the region counters are rebuilt by repeated subtraction, which holds s_ready low;
// s_ready is also low during the transfer itself.
module label_mode_downsample #(
    parameter int MAX_WIDTH  = lmd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_FACTOR = lmd_pkg::MAX_FACTOR_DEF,
    parameter int NUM_LABELS = lmd_pkg::NUM_LABELS_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [1:0]  cfg_index,
    input  wire  [12:0] cfg_data,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [7:0]  s_label,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [7:0]  m_out_label,
    output logic [11:0] m_out_row,
    output logic [8:0]  m_out_col,
    output logic        m_frame_last
);

    logic [4:0]  factor_reg;
    logic [9:0]  width_reg;
    logic [12:0] height_reg;
    logic        cfg_write;
    logic [6:0]  f_c;
    logic [13:0] ff;

    lmd_pkg::lmd_cfg_t  cfg;
    lmd_pkg::lmd_item_t push_item, q_item;
    logic push_valid, push_ready, q_valid, q_ready, back_run;

    always_comb begin
        cfg_ready = 1'b1;
        cfg_write = cfg_valid && cfg_ready;

        if (factor_reg == 5'd0) begin
            f_c = 7'd1;
        end else if (7'(factor_reg) > 7'(MAX_FACTOR)) begin
            f_c = 7'(MAX_FACTOR);
        end else begin
            f_c = 7'(factor_reg);
        end
        ff    = 14'(f_c) * 14'(f_c);
        cfg.f = f_c;
        cfg.half = ff[13:1];

        if (width_reg == 10'd0) begin
            cfg.w = 13'd1;
        end else if (13'(width_reg) > 13'(MAX_WIDTH)) begin
            cfg.w = 13'(MAX_WIDTH);
        end else begin
            cfg.w = 13'(width_reg);
        end

        if (height_reg == 13'd0) begin
            cfg.h = 13'd1;
        end else if (height_reg > lmd_pkg::HEIGHT_MAX) begin
            cfg.h = lmd_pkg::HEIGHT_MAX;
        end else begin
            cfg.h = height_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            factor_reg <= lmd_pkg::FACTOR_RST;
            width_reg  <= lmd_pkg::WIDTH_RST;
            height_reg <= lmd_pkg::HEIGHT_RST;
        end else if (cfg_write) begin
            case (cfg_index)
                lmd_pkg::CFG_FACTOR: factor_reg <= cfg_data[4:0];
                lmd_pkg::CFG_WIDTH:  width_reg  <= cfg_data[9:0];
                lmd_pkg::CFG_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    lmd_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_FACTOR (MAX_FACTOR),
        .NUM_LABELS (NUM_LABELS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .cfg_write  (cfg_write),
        .back_run   (back_run),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_label    (s_label),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    lmd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_item   (push_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    lmd_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .NUM_LABELS (NUM_LABELS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .back_run     (back_run),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_item       (q_item),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_label  (m_out_label),
        .m_out_row    (m_out_row),
        .m_out_col    (m_out_col),
        .m_frame_last (m_frame_last)
    );

endmodule

`default_nettype wire

// File: verif/label_mode_downsample_test.sv
// Self-checking testbench for label_mode_downsample: drives label maps in raster order
// and checks every emitted region vote against an internal majority-vote predictor.
// Depends on lmd_pkg and the label_mode_downsample RTL.
`timescale 1ns / 100ps

module label_mode_downsample_test;

    typedef struct packed {
        logic [7:0]  lab;
        logic [11:0] row;
        logic [8:0]  col;
        logic        last;
    } region_vote_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [12:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_label;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_out_label;
    logic [11:0] m_out_row;
    logic [8:0]  m_out_col;
    logic        m_frame_last;

    label_mode_downsample u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_label      (s_label),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_label  (m_out_label),
        .m_out_row    (m_out_row),
        .m_out_col    (m_out_col),
        .m_frame_last (m_frame_last)
    );

    // Predictor state: raw register values and a per-column histogram store.
    logic [4:0]  reg_factor;
    logic [9:0]  reg_width;
    logic [12:0] reg_height;
    logic [8:0]  hist_bins [0:512*256-1];
    logic [7:0]  mode_label [0:511];
    logic [8:0]  mode_count [0:511];
    int          pix_row;
    int          pix_col;

    logic [7:0]   label_queue [$];
    region_vote_t vote_queue [$];
    int           error_count;
    int           burst_left;
    int           gap_left;
    logic         hold_req;
    int           hold_left;
    logic         hold_done;

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic int clamp_int(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    task automatic predict_vote(input logic [7:0] lab);
        int f, w, h, ocols, orows, oc, orow, base, cnt;
        region_vote_t vote;
        f = clamp_int(reg_factor, 1, 16);
        w = clamp_int(reg_width, 1, 512);
        h = clamp_int(reg_height, 1, 4096);
        ocols = w / f;
        orows = h / f;
        if (pix_col < ocols * f && pix_row < orows * f) begin
            oc = pix_col / f;
            orow = pix_row / f;
            base = oc * 256;
            cnt = hist_bins[base + lab];
            if (cnt < 511) cnt++;
            hist_bins[base + lab] = 9'(cnt);
            if (cnt > mode_count[oc] || (cnt == mode_count[oc] && lab < mode_label[oc])) begin
                mode_count[oc] = 9'(cnt);
                mode_label[oc] = lab;
            end
            if (pix_row % f == f - 1 && pix_col % f == f - 1) begin
                vote.lab = (mode_count[oc] > (f * f) / 2) ? mode_label[oc]
                                                          : lmd_pkg::IGNORE_LABEL;
                vote.row = 12'(orow);
                vote.col = 9'(oc);
                vote.last = (orow == orows - 1) && (oc == ocols - 1);
                vote_queue.push_back(vote);
                for (int i = 0; i < 256; i++) hist_bins[base + i] = '0;
                mode_count[oc] = '0;
                mode_label[oc] = '0;
            end
        end
        if (pix_col + 1 >= w) begin
            pix_col = 0;
            pix_row = (pix_row + 1 >= h) ? 0 : pix_row + 1;
        end else begin
            pix_col = pix_col + 1;
        end
    endtask

    // Input driver: bursts of transfers separated by random gaps.
    always @(posedge aclk) begin
        logic next_valid;
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_label <= '0;
            burst_left <= 8;
            gap_left <= 0;
        end else begin
            if (s_valid && s_ready) predict_vote(s_label);
            if (!s_valid || s_ready) begin
                next_valid = 1'b0;
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                end else if (label_queue.size() > 0) begin
                    next_valid = 1'b1;
                    s_label <= label_queue.pop_front();
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end
                s_valid <= next_valid;
            end
        end
    end

    // One long receiver hold-off, requested by the stimulus.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_req && !hold_done && hold_left == 0) begin
            hold_left <= 400;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Output monitor: checks each result transfer against the oldest expected vote.
    always @(posedge aclk) begin
        region_vote_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (vote_queue.size() == 0) begin
                    report_mismatch("unexpected result, label", m_out_label, -1);
                end else begin
                    want = vote_queue.pop_front();
                    if (m_out_label !== want.lab) report_mismatch("out_label", m_out_label, want.lab);
                    if (m_out_row !== want.row) report_mismatch("out_row", m_out_row, want.row);
                    if (m_out_col !== want.col) report_mismatch("out_col", m_out_col, want.col);
                    if (m_frame_last !== want.last)
                        report_mismatch("frame_last", m_frame_last, want.last);
                end
            end
            if (hold_left > 1 || (hold_req && !hold_done))
                m_ready <= 1'b0;
            else if (($time / 2000) % 3 == 0)
                m_ready <= 1'b1;
            else
                m_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    task automatic write_reg(input lmd_pkg::lmd_cfg_idx_t idx, input logic [12:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            lmd_pkg::CFG_FACTOR: reg_factor = value[4:0];
            lmd_pkg::CFG_WIDTH:  reg_width = value[9:0];
            default:             reg_height = value;
        endcase
    endtask

    task automatic set_shape(input int f, input int w, input int h);
        write_reg(lmd_pkg::CFG_FACTOR, 13'(f));
        write_reg(lmd_pkg::CFG_WIDTH, 13'(w));
        write_reg(lmd_pkg::CFG_HEIGHT, 13'(h));
    endtask

    // Waits until every label is accepted and every vote has arrived, then lets
    // in-flight pixels that produce no result drain.
    task automatic wait_idle();
        do @(posedge aclk); while (label_queue.size() > 0 || s_valid || vote_queue.size() > 0);
        repeat (30) @(posedge aclk);
    endtask

    task automatic push_labels(input int n, input int palette_size);
        logic [7:0] palette [4];
        for (int i = 0; i < 4; i++) palette[i] = 8'($urandom_range(0, 255));
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) < 8)
                label_queue.push_back(palette[$urandom_range(0, palette_size - 1)]);
            else
                label_queue.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        int total, f, w, h, n;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = lmd_pkg::CFG_FACTOR;
        cfg_data = '0;
        hold_req = 1'b0;
        error_count = 0;
        reg_factor = lmd_pkg::FACTOR_RST;
        reg_width = lmd_pkg::WIDTH_RST;
        reg_height = lmd_pkg::HEIGHT_RST;
        pix_row = 0;
        pix_col = 0;
        for (int i = 0; i < 512 * 256; i++) hist_bins[i] = '0;
        for (int i = 0; i < 512; i++) begin
            mode_label[i] = '0;
            mode_count[i] = '0;
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // One-pixel regions pass each label straight through.
        set_shape(1, 1, 1);
        label_queue = '{8'd0, 8'd255, 8'h55, 8'hAA};
        wait_idle();
        // A two-two tie yields the ignore label; three of four wins.
        set_shape(2, 4, 2);
        label_queue = '{8'd3, 8'd1, 8'd7, 8'd7, 8'd1, 8'd3, 8'd7, 8'd9};
        wait_idle();
        // The right column that does not fill a region is dropped.
        set_shape(3, 4, 3);
        label_queue = '{8'd5, 8'd5, 8'd5, 8'd9, 8'd5, 8'd5, 8'd2, 8'd9, 8'd1, 8'd1, 8'd5, 8'd9};
        wait_idle();
        // Zero registers clamp to one.
        set_shape(0, 0, 0);
        label_queue = '{8'd42};
        wait_idle();
        // Oversized registers clamp to their maxima; nothing completes here.
        set_shape(31, 1023, 8191);
        label_queue = '{8'd6, 8'd6};
        wait_idle();

        // Long receiver hold-off while every pixel produces a result.
        set_shape(1, 5, 3);
        push_labels(120, 4);
        hold_req = 1'b1;
        wait_idle();
        total = 120;

        while (total < 1400) begin
            n = $urandom_range(40, 160);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: f = $urandom_range(1, 3);
                6, 7:             f = $urandom_range(4, 5);
                8:                f = 16;
                default:          f = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(17, 31);
            endcase
            w = $urandom_range(1, 24);
            h = $urandom_range(1, 20);
            if (f >= 16) begin
                w = $urandom_range(32, 40);
                h = 16;
                n = 560;
            end else if ($urandom_range(0, 15) == 0) begin
                w = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(513, 1023);
                h = $urandom_range(4097, 8191);
            end
            set_shape(f, w, h);
            push_labels(n, $urandom_range(1, 3));
            wait_idle();
            total += n;
        end

        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #8ms;
        $display("simulation failed");
        $finish;
    end

endmodule
